// File: hw/rtl/pis_pkg.sv
// ----------------------------------------------------------------------------
// Particle integration step package
// Shared types, register indexes and pipeline latencies for the particle
// integration step block.
// ----------------------------------------------------------------------------
package pis_pkg;

  // Velocity friction after a bounce (0.6 in Q0.16) and the rest threshold.
  localparam int FRICTION_Q16 = 39322;
  localparam int REST_LIMIT   = 256;

  // Quotient width of the life-fraction divider, one bit per stage.
  localparam int DIV_W = 16;

  // Register stages of each unit and the delay that lines the two up.
  localparam int MOTION_LAT = 8;
  localparam int SHADE_LAT  = DIV_W + 2;
  localparam int ALIGN_LAT  = SHADE_LAT - MOTION_LAT;
  localparam int PIPE_LAT   = SHADE_LAT + 1;

  typedef enum logic [1:0] {
    CFG_FRAME_STEP    = 2'd0,
    CFG_GRAVITY_Y     = 2'd1,
    CFG_GROUND_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] frame_step;
    logic [15:0] gravity_y;
    logic [15:0] ground_height;
  } cfg_t;

  typedef struct packed {
    logic [47:0] position;
    logic [47:0] velocity;
    logic [47:0] swirl_axis;
    logic [47:0] motion_coeffs;
    logic [15:0] spin_rate;
    logic [31:0] buoyancy;
    logic [15:0] rotation;
    logic [31:0] life_pair;
    logic [31:0] size_ends;
    logic [31:0] start_color;
    logic [31:0] end_color;
    logic [1:0]  flags;
  } item_t;

  typedef struct packed {
    logic [47:0] position;
    logic [47:0] velocity;
    logic [15:0] rotation;
  } motion_res_t;

  typedef struct packed {
    logic [15:0] life_left;
    logic [15:0] cur_size;
    logic [31:0] cur_color;
    logic        still_active;
  } shade_res_t;

  typedef struct packed {
    logic        active;
    logic        expired;
    logic [15:0] life;
    logic [15:0] newlife;
    logic [15:0] size0;
    logic [15:0] size1;
    logic [31:0] color0;
    logic [31:0] color1;
  } shade_pay_t;

endpackage

// File: hw/rtl/particle_integration_step.sv
// ----------------------------------------------------------------------------
// Particle integration step
// Advances one particle record by one frame: turbulence, drag, gravity or
// buoyancy, position, ground bounce, spin, lifetime and size/colour lerp.
// ----------------------------------------------------------------------------
// Usage:
//   A record is transferred in at a clock edge where start is high and busy is
//   low. busy is high during reset and in the first cycle after it, so from
//   then on a record may be transferred in every cycle.
//   Each record gives exactly one result, shown on the out_ ports for one
//   cycle with out_valid high, in input order.
//   The receiver cannot hold results off, and none is needed: the pipeline
//   never stalls.
//   Throughput is one record per cycle. Latency is set by the life-fraction
//   divider, which produces one quotient bit per stage (16 stages), plus the
//   entry stage, the interpolation stage and the output register. The motion
//   path takes 8 stages and is delayed to line up with it.
//   The cfg_ port writes frame_step, gravity_y and ground_height and should
//   only be used when no record is in flight. Reset clears all valid bits and
//   loads the default register values.
// ----------------------------------------------------------------------------
module particle_integration_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [47:0]        in_position,
  input  logic [47:0]        in_velocity,
  input  logic [47:0]        in_swirl_axis,
  input  logic [47:0]        in_motion_coeffs,
  input  logic signed [15:0] in_spin_rate,
  input  logic [31:0]        in_buoyancy,
  input  logic signed [15:0] in_rotation,
  input  logic [31:0]        in_life_pair,
  input  logic [31:0]        in_size_ends,
  input  logic [31:0]        in_start_color,
  input  logic [31:0]        in_end_color,
  input  logic [1:0]         in_flags,
  output logic               out_valid,
  output logic [47:0]        out_new_position,
  output logic [47:0]        out_new_velocity,
  output logic signed [15:0] out_new_rotation,
  output logic [15:0]        out_life_left,
  output logic [15:0]        out_cur_size,
  output logic [31:0]        out_cur_color,
  output logic               out_still_active,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import pis_pkg::*;

  // Busy for one cycle after reset.
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;

  logic in_xfer;
  assign in_xfer = start && !busy_r;

  // Configuration registers.
  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_step    <= 16'd1092;
      cfg_r.gravity_y     <= 16'hff05;
      cfg_r.ground_height <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_STEP:    cfg_r.frame_step    <= cfg_wdata;
        CFG_GRAVITY_Y:     cfg_r.gravity_y     <= cfg_wdata;
        CFG_GROUND_HEIGHT: cfg_r.ground_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  item_t item;
  always_comb begin
    item.position      = in_position;
    item.velocity      = in_velocity;
    item.swirl_axis    = in_swirl_axis;
    item.motion_coeffs = in_motion_coeffs;
    item.spin_rate     = in_spin_rate;
    item.buoyancy      = in_buoyancy;
    item.rotation      = in_rotation;
    item.life_pair     = in_life_pair;
    item.size_ends     = in_size_ends;
    item.start_color   = in_start_color;
    item.end_color     = in_end_color;
    item.flags         = in_flags;
  end

  // Motion and lifetime units run side by side.
  logic        mo_vld;
  motion_res_t mo_res;
  logic        sh_vld;
  shade_res_t  sh_res;

  pis_motion u_motion (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_xfer),
    .item    (item),
    .cfg     (cfg_r),
    .out_vld (mo_vld),
    .res     (mo_res)
  );

  pis_shade u_shade (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_xfer),
    .item    (item),
    .cfg     (cfg_r),
    .out_vld (sh_vld),
    .res     (sh_res)
  );

  // Delay line that lines the motion result up with the lifetime result.
  motion_res_t dly_r [ALIGN_LAT];
  always_ff @(posedge clk) begin
    dly_r[0] <= mo_res;
    for (int k = 1; k < ALIGN_LAT; k++) dly_r[k] <= dly_r[k-1];
  end

  // Output register.
  logic        out_valid_r;
  motion_res_t out_mo_r;
  shade_res_t  out_sh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sh_vld;
    end
    out_mo_r <= dly_r[ALIGN_LAT-1];
    out_sh_r <= sh_res;
  end

  assign out_valid        = out_valid_r;
  assign out_new_position = out_mo_r.position;
  assign out_new_velocity = out_mo_r.velocity;
  assign out_new_rotation = $signed(out_mo_r.rotation);
  assign out_life_left    = out_sh_r.life_left;
  assign out_cur_size     = out_sh_r.cur_size;
  assign out_cur_color    = out_sh_r.cur_color;
  assign out_still_active = out_sh_r.still_active;

  // Every result stems from a transfer a fixed number of cycles earlier.
  a_result_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, PIPE_LAT))
    else $error("result without a matching input transfer");

  // The two units stay in step.
  a_units_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sh_vld |-> $past(mo_vld, ALIGN_LAT))
    else $error("lifetime and motion results out of step");

  // A live particle always has life left.
  a_live_has_life: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_still_active |-> out_life_left != 16'd0)
    else $error("live particle with no life left");

  // No transfer is taken in the cycle after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy not raised after reset");

endmodule

// File: hw/rtl/pis_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Computes floor(rem_in * 2^W / den_in) for rem_in < den_in, one quotient bit
// per register stage, and carries a payload alongside.
// ----------------------------------------------------------------------------
module pis_div #(
  parameter int W  = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  den_in,
  input  logic [PW-1:0] pay_in,
  output logic          out_vld,
  output logic [W-1:0]  quo,
  output logic [PW-1:0] pay_out
);

  logic          vld_r [W];
  logic [W-1:0]  rem_r [W];
  logic [W-1:0]  den_r [W];
  logic [W-1:0]  quo_r [W];
  logic [PW-1:0] pay_r [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic          vld_s;
    logic [W-1:0]  rem_s;
    logic [W-1:0]  den_s;
    logic [W-1:0]  quo_s;
    logic [PW-1:0] pay_s;
    logic [W:0]    sh;
    logic          ge;

    // Stage inputs come from the ports for the first step.
    if (k == 0) begin : g_first
      assign vld_s = in_vld;
      assign rem_s = rem_in;
      assign den_s = den_in;
      assign quo_s = '0;
      assign pay_s = pay_in;
    end else begin : g_next
      assign vld_s = vld_r[k-1];
      assign rem_s = rem_r[k-1];
      assign den_s = den_r[k-1];
      assign quo_s = quo_r[k-1];
      assign pay_s = pay_r[k-1];
    end

    // One trial subtraction per stage.
    assign sh = {rem_s, 1'b0};
    assign ge = (sh >= {1'b0, den_s});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_s;
      end
      rem_r[k] <= ge ? W'(sh - {1'b0, den_s}) : W'(sh);
      den_r[k] <= den_s;
      quo_r[k] <= {quo_s[W-2:0], ge};
      pay_r[k] <= pay_s;
    end
  end

  assign out_vld = vld_r[W-1];
  assign quo     = quo_r[W-1];
  assign pay_out = pay_r[W-1];

endmodule

// File: hw/rtl/pis_motion.sv
// ----------------------------------------------------------------------------
// Particle motion pipeline
// Eight stages: turbulence, drag, gravity or buoyancy, position integration,
// ground bounce and spin.
// ----------------------------------------------------------------------------
module pis_motion (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  pis_pkg::item_t       item,
  input  pis_pkg::cfg_t        cfg,
  output logic                 out_vld,
  output pis_pkg::motion_res_t res
);
  import pis_pkg::*;

  typedef struct packed {
    logic        active;
    logic        gnd_en;
    logic [15:0] turb;
    logic [15:0] drag;
    logic [15:0] bounce;
    logic [47:0] pos_in;
    logic [47:0] vel_in;
    logic [15:0] rot_in;
    logic [15:0] rot_new;
    logic [15:0] grav_dv;
  } carry_t;

  function automatic logic signed [15:0] sat16(input logic signed [55:0] x);
    logic signed [15:0] r;
    if (x > 56'sd32767) r = 16'sh7fff;
    else if (x < -56'sd32768) r = 16'sh8000;
    else r = x[15:0];
    return r;
  endfunction

  logic signed [16:0] dts;
  assign dts = $signed({1'b0, cfg.frame_step});

  logic                vld_r [MOTION_LAT];
  carry_t              car_r [MOTION_LAT-1];
  carry_t              car_nxt;
  logic signed [32:0]  s1_c_r   [3];
  logic signed [32:0]  s1_c_nxt [3];
  logic signed [33:0]  s2_t1_r   [3];
  logic signed [33:0]  s2_t1_nxt [3];
  logic signed [15:0]  s3_v_r   [3];
  logic signed [15:0]  s3_v_nxt [3];
  logic signed [15:0]  s4_v_r   [3];
  logic signed [32:0]  s4_vd_r   [3];
  logic signed [32:0]  s4_vd_nxt [3];
  logic signed [15:0]  s5_v_r   [3];
  logic signed [15:0]  s5_v_nxt [3];
  logic signed [15:0]  s6_v_r   [3];
  logic signed [15:0]  s6_v_nxt [3];
  logic signed [15:0]  s7_v_r   [3];
  logic signed [15:0]  s7_p_r   [3];
  logic signed [15:0]  s7_p_nxt [3];
  motion_res_t         res_r;
  motion_res_t         res_nxt;

  // Stage 1: cross product of axis and velocity, spin, gravity or buoyancy step.
  logic signed [15:0] vin [3];
  logic signed [15:0] ain [3];
  logic signed [31:0] xp  [6];
  logic signed [15:0] delay;
  logic signed [15:0] buoy_force;
  logic signed [15:0] accel;
  logic signed [16:0] age;
  logic               buoy_on;
  logic signed [32:0] rot_prod;
  logic signed [32:0] grav_prod;
  logic signed [32:0] rot_rnd;
  logic signed [32:0] grav_rnd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vin[i] = $signed(item.velocity[16*i +: 16]);
      ain[i] = $signed(item.swirl_axis[16*i +: 16]);
    end
  end

  assign xp[0] = ain[1] * vin[2];
  assign xp[1] = ain[2] * vin[1];
  assign xp[2] = ain[2] * vin[0];
  assign xp[3] = ain[0] * vin[2];
  assign xp[4] = ain[0] * vin[1];
  assign xp[5] = ain[1] * vin[0];

  always_comb begin
    s1_c_nxt[0] = 33'(xp[0]) - 33'(xp[1]);
    s1_c_nxt[1] = 33'(xp[2]) - 33'(xp[3]);
    s1_c_nxt[2] = 33'(xp[4]) - 33'(xp[5]);
    delay      = $signed(item.buoyancy[15:0]);
    buoy_force = $signed(item.buoyancy[31:16]);
    age        = $signed({1'b0, item.life_pair[31:16]}) - $signed({1'b0, item.life_pair[15:0]});
    buoy_on    = !delay[15] && (age > 17'(delay));
    accel      = buoy_on ? buoy_force : $signed(cfg.gravity_y);
    rot_prod   = $signed(item.spin_rate) * dts;
    grav_prod  = accel * dts;
    rot_rnd    = (rot_prod + 33'sd32768) >>> 16;
    grav_rnd   = (grav_prod + 33'sd32768) >>> 16;
    car_nxt.active  = item.flags[0];
    car_nxt.gnd_en  = item.flags[1];
    car_nxt.turb    = item.motion_coeffs[15:0];
    car_nxt.drag    = item.motion_coeffs[31:16];
    car_nxt.bounce  = item.motion_coeffs[47:32];
    car_nxt.pos_in  = item.position;
    car_nxt.vel_in  = item.velocity;
    car_nxt.rot_in  = item.rotation;
    car_nxt.rot_new = item.rotation + rot_rnd[15:0];
    car_nxt.grav_dv = sat16(56'(grav_rnd));
  end

  // Stage 2: cross product scaled by turbulence.
  logic signed [49:0] tp [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tp[i]        = s1_c_r[i] * $signed({1'b0, car_r[0].turb});
      s2_t1_nxt[i] = 34'((tp[i] + 50'sd32768) >>> 16);
    end
  end

  // Stage 3: turbulence scaled by dt and added to the velocity.
  logic signed [50:0] dp  [3];
  logic signed [50:0] dv3 [3];
  logic signed [15:0] v_in3 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_in3[i] = $signed(car_r[1].vel_in[16*i +: 16]);
      dp[i]    = s2_t1_r[i] * dts;
      dv3[i]   = (dp[i] + 51'sd32768) >>> 16;
      s3_v_nxt[i] = (car_r[1].turb != 16'd0) ? sat16(56'(v_in3[i]) + 56'(dv3[i])) : v_in3[i];
    end
  end

  // Stage 4: velocity times drag.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_vd_nxt[i] = s3_v_r[i] * $signed({1'b0, car_r[2].drag});
    end
  end

  // Stage 5: drag scaled by dt and taken off the velocity.
  logic signed [49:0] ddp [3];
  logic signed [49:0] dd5 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ddp[i] = s4_vd_r[i] * dts;
      dd5[i] = (ddp[i] + 50'sd8388608) >>> 24;
      s5_v_nxt[i] = (car_r[3].drag != 16'd0) ? sat16(56'(s4_v_r[i]) - 56'(dd5[i])) : s4_v_r[i];
    end
  end

  // Stage 6: gravity or buoyancy on the vertical component.
  always_comb begin
    s6_v_nxt[0] = s5_v_r[0];
    s6_v_nxt[1] = sat16(56'(s5_v_r[1]) + 56'($signed(car_r[4].grav_dv)));
    s6_v_nxt[2] = s5_v_r[2];
  end

  // Stage 7: position integration.
  logic signed [32:0] pdp [3];
  logic signed [32:0] pdr [3];
  logic signed [15:0] pd  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdp[i] = s6_v_r[i] * dts;
      pdr[i] = (pdp[i] + 33'sd32768) >>> 16;
      pd[i]  = sat16(56'(pdr[i]));
      s7_p_nxt[i] = sat16(56'($signed(car_r[5].pos_in[16*i +: 16])) + 56'(pd[i]));
    end
  end

  // Stage 8: ground bounce, rest test and pass-through of inactive records.
  logic signed [16:0] nvy;
  logic signed [33:0] bprod;
  logic signed [33:0] brnd;
  logic signed [15:0] by;
  logic signed [32:0] fprod [2];
  logic signed [32:0] frnd  [2];
  logic signed [15:0] fv    [2];
  logic               hit;
  logic               rest;
  logic signed [15:0] vo [3];
  logic signed [15:0] po [3];
  always_comb begin
    nvy      = -17'(s7_v_r[1]);
    bprod    = nvy * $signed({1'b0, car_r[6].bounce});
    brnd     = (bprod + 34'sd128) >>> 8;
    by       = sat16(56'(brnd));
    fprod[0] = s7_v_r[0] * $signed(17'(FRICTION_Q16));
    fprod[1] = s7_v_r[2] * $signed(17'(FRICTION_Q16));
    for (int j = 0; j < 2; j++) begin
      frnd[j] = (fprod[j] + 33'sd32768) >>> 16;
      fv[j]   = sat16(56'(frnd[j]));
    end
    hit  = car_r[6].gnd_en && (s7_p_r[1] <= $signed(cfg.ground_height)) && (s7_v_r[1] < 0);
    rest = (by < REST_LIMIT) && (by > -REST_LIMIT);
    for (int i = 0; i < 3; i++) begin
      vo[i] = s7_v_r[i];
      po[i] = s7_p_r[i];
    end
    if (hit) begin
      po[1] = $signed(cfg.ground_height);
      if (rest) begin
        vo[0] = '0;
        vo[1] = '0;
        vo[2] = '0;
      end else begin
        vo[0] = fv[0];
        vo[1] = by;
        vo[2] = fv[1];
      end
    end
    if (car_r[6].active) begin
      res_nxt.position = {po[2], po[1], po[0]};
      res_nxt.velocity = {vo[2], vo[1], vo[0]};
      res_nxt.rotation = car_r[6].rot_new;
    end else begin
      res_nxt.position = car_r[6].pos_in;
      res_nxt.velocity = car_r[6].vel_in;
      res_nxt.rotation = car_r[6].rot_in;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MOTION_LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < MOTION_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    car_r[0] <= car_nxt;
    for (int k = 1; k < MOTION_LAT - 1; k++) car_r[k] <= car_r[k-1];
    for (int i = 0; i < 3; i++) begin
      s1_c_r[i]  <= s1_c_nxt[i];
      s2_t1_r[i] <= s2_t1_nxt[i];
      s3_v_r[i]  <= s3_v_nxt[i];
      s4_v_r[i]  <= s3_v_r[i];
      s4_vd_r[i] <= s4_vd_nxt[i];
      s5_v_r[i]  <= s5_v_nxt[i];
      s6_v_r[i]  <= s6_v_nxt[i];
      s7_v_r[i]  <= s6_v_r[i];
      s7_p_r[i]  <= s7_p_nxt[i];
    end
    res_r <= res_nxt;
  end

  assign out_vld = vld_r[MOTION_LAT-1];
  assign res     = res_r;

endmodule

// File: hw/rtl/pis_shade.sv
// ----------------------------------------------------------------------------
// Particle lifetime and appearance pipeline
// Life decrement, expiry, life fraction through a pipelined divider and
// size and colour interpolation.
// ----------------------------------------------------------------------------
module pis_shade (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  pis_pkg::item_t      item,
  input  pis_pkg::cfg_t       cfg,
  output logic                out_vld,
  output pis_pkg::shade_res_t res
);
  import pis_pkg::*;

  function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] t);
    logic signed [16:0] d;
    logic signed [33:0] pr;
    logic signed [33:0] rs;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    pr = d * $signed({1'b0, t});
    rs = (pr + 34'sd32768) >>> 16;
    return a + rs[15:0];
  endfunction

  // Entry stage: new life, expiry and the divider operands.
  logic [8:0]         dt_q;
  logic signed [17:0] nl;
  logic               expired;
  logic               t_zero;
  logic [15:0]        maxl;
  logic [15:0]        num_nxt;
  logic [15:0]        den_nxt;
  shade_pay_t         pay_nxt;

  always_comb begin
    maxl    = item.life_pair[31:16];
    dt_q    = 9'((17'(cfg.frame_step) + 17'd128) >> 8);
    nl      = $signed({2'b0, item.life_pair[15:0]}) - $signed({9'b0, dt_q});
    expired = (nl <= 0);
    t_zero  = expired || !(nl < $signed({2'b0, maxl}));
    num_nxt = t_zero ? 16'd0 : maxl - nl[15:0];
    den_nxt = t_zero ? 16'd1 : maxl;
    pay_nxt.active  = item.flags[0];
    pay_nxt.expired = expired;
    pay_nxt.life    = item.life_pair[15:0];
    pay_nxt.newlife = nl[15:0];
    pay_nxt.size0   = item.size_ends[15:0];
    pay_nxt.size1   = item.size_ends[31:16];
    pay_nxt.color0  = item.start_color;
    pay_nxt.color1  = item.end_color;
  end

  logic        a_vld_r;
  logic [15:0] a_num_r;
  logic [15:0] a_den_r;
  shade_pay_t  a_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    a_num_r <= num_nxt;
    a_den_r <= den_nxt;
    a_pay_r <= pay_nxt;
  end

  // Life fraction t = (max - life) / max in Q0.16.
  logic                        d_vld;
  logic [DIV_W-1:0]            d_quo;
  logic [$bits(shade_pay_t)-1:0] d_pay_bits;
  shade_pay_t                  d_pay;

  pis_div #(
    .W  (DIV_W),
    .PW ($bits(shade_pay_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (a_vld_r),
    .rem_in  (a_num_r),
    .den_in  (a_den_r),
    .pay_in  (a_pay_r),
    .out_vld (d_vld),
    .quo     (d_quo),
    .pay_out (d_pay_bits)
  );

  assign d_pay = shade_pay_t'(d_pay_bits);

  // Interpolation and result selection.
  shade_res_t res_nxt;
  logic [15:0] ch [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ch[i] = lerp16({8'd0, d_pay.color0[8*i +: 8]}, {8'd0, d_pay.color1[8*i +: 8]}, d_quo);
    end
    if (!d_pay.active) begin
      res_nxt.life_left    = d_pay.life;
      res_nxt.cur_size     = d_pay.size0;
      res_nxt.cur_color    = d_pay.color0;
      res_nxt.still_active = 1'b0;
    end else if (d_pay.expired) begin
      res_nxt.life_left    = '0;
      res_nxt.cur_size     = d_pay.size0;
      res_nxt.cur_color    = d_pay.color0;
      res_nxt.still_active = 1'b0;
    end else begin
      res_nxt.life_left    = d_pay.newlife;
      res_nxt.cur_size     = lerp16(d_pay.size0, d_pay.size1, d_quo);
      res_nxt.cur_color    = {ch[3][7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
      res_nxt.still_active = 1'b1;
    end
  end

  logic       vld_r;
  shade_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d_vld;
    end
    res_r <= res_nxt;
  end

  assign out_vld = vld_r;
  assign res     = res_r;

endmodule
